// ----- rtl/esa_pkg.sv -----
// Shared types and constants for the entity slot allocator with mask query.
`default_nettype none

package esa_pkg;

   // Default table size
   localparam int MAX_SLOTS_DEFAULT = 32;

   // Field widths
   localparam int SLOT_W       = 5;
   localparam int MASK_W       = 31;
   localparam int MAX_RESULTS  = 32;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS);

   // Operation codes
   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_QUERY  = 2'd3
   } esa_op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_REFUSED = 2'd2
   } esa_status_type;

   // Request item
   typedef struct packed {
      esa_op_type          op;
      logic [SLOT_W-1:0]   slot;
      logic [MASK_W-1:0]   component_mask;
   } esa_req_type;

   // Result item
   typedef struct packed {
      logic [SLOT_W-1:0]   slot_id;
      esa_status_type      status;
      logic                match_valid;
      logic                last;
   } esa_rsp_type;

   // Broadcast control to the row of slot cells
   typedef struct packed {
      logic                create_go;
      logic                remove_go;
      logic                toggle_go;
      logic                query_load;
      logic                scan_shift;
      logic                scan_clear;
      logic [MASK_W-1:0]   mask;
   } esa_cell_ctl_type;

   // Control to the free-list stack cells
   typedef struct packed {
      logic push;
      logic pop;
   } esa_stack_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/esa_slot_cell.sv -----
// One slot of the table: alive bit, component mask and a query match bit in the scan chain.
`default_nettype none

module esa_slot_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  esa_pkg::esa_cell_ctl_type ctl,
   input  logic                     create_sel,
   input  logic                     slot_sel,
   input  logic                     match_from_up,
   output logic                     alive,
   output logic                     match_now,
   output logic                     match_held
);
   import esa_pkg::*;

   logic              alive_ff, alive_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              match_ff, match_in;

   // Compare the stored mask against the query mask
   assign match_now  = alive_ff && ((mask_ff & ctl.mask) == ctl.mask);
   assign alive      = alive_ff;
   assign match_held = match_ff;

   // Update the slot word
   always_comb begin
      alive_in = alive_ff;
      mask_in  = mask_ff;
      priority if (ctl.create_go && create_sel) begin
         alive_in = 1'b1;
         mask_in  = ctl.mask;
      end else if (ctl.remove_go && slot_sel) begin
         alive_in = 1'b0;
         mask_in  = '0;
      end else if (ctl.toggle_go && slot_sel) begin
         mask_in  = mask_ff ^ ctl.mask;
      end
   end

   // Load, shift or drop the match bit
   always_comb begin
      match_in = match_ff;
      priority if (ctl.scan_clear) begin
         match_in = 1'b0;
      end else if (ctl.query_load) begin
         match_in = match_now;
      end else if (ctl.scan_shift) begin
         match_in = match_from_up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         alive_ff <= alive_in;
         match_ff <= match_in;
      end
   end

   // Mask is only seen while the slot is alive, and create always writes it
   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end

endmodule

`default_nettype wire

// ----- rtl/esa_stack_cell.sv -----
// One entry of the shifting free-list stack; cell zero is the top.
`default_nettype none

module esa_stack_cell #(
   parameter int IDX_W       = $clog2(esa_pkg::MAX_SLOTS_DEFAULT),
   parameter int RESET_VALUE = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  esa_pkg::esa_stack_ctl_type ctl,
   input  logic [IDX_W-1:0]          from_above,
   input  logic [IDX_W-1:0]          from_below,
   output logic [IDX_W-1:0]          entry
);
   import esa_pkg::*;

   logic [IDX_W-1:0] entry_ff, entry_in;

   // Push moves entries down, pop moves them up
   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.push) begin
         entry_in = from_above;
      end else if (ctl.pop) begin
         entry_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= IDX_W'(RESET_VALUE);
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/entity_slot_allocator_mask_query_top.sv -----
// Top level of the entity slot allocator: cell rows, handshake, scan control and result register.
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | op, slot, component_mask
//  rsp     | out       | rsp_valid/stall  | slot_id, status, match_valid, last
//
// Create, remove and toggle give one result each; items follow back to back while the
// result register drains.
// A query with matches holds the input while it is scanned: the match bits shift one slot
// per cycle down the row of slot cells, unless a stalled result holds a match at cell zero,
// and the scan ends right after the last match. A query without a match gives a single result.
// Reset is synchronous; stack and table are ready once it is released.
// A stalled result holds the result register and, during a query, holds the scan while a match waits at cell zero.
`default_nettype none

module entity_slot_allocator_mask_query_top #(
   parameter int MAX_SLOTS = esa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  esa_pkg::esa_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esa_pkg::esa_rsp_type rsp_item
);
   import esa_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   logic                    accept;
   logic                    out_free;
   logic                    scan_busy;
   logic                    emit;
   logic                    rest_zero;
   logic                    cap_hit;
   logic                    full;
   logic                    refused;
   logic                    slot_alive;
   logic                    any_match;
   logic                    rsp_load;
   logic [IDX_W-1:0]        slot_idx;
   logic [MAX_SLOTS-1:0]    slot_hit;
   logic [MAX_SLOTS-1:0]    create_hit;
   logic [MAX_SLOTS-1:0]    alive_vec;
   logic [MAX_SLOTS-1:0]    match_now_vec;
   logic [MAX_SLOTS-1:0]    match_vec;
   logic [MAX_SLOTS-1:0]    match_up;
   logic [IDX_W-1:0]        stack_entry [MAX_SLOTS];
   logic [IDX_W-1:0]        stack_above [MAX_SLOTS];
   logic [IDX_W-1:0]        stack_below [MAX_SLOTS];
   esa_cell_ctl_type        cell_ctl;
   esa_stack_ctl_type       stack_ctl;
   esa_rsp_type             rsp_in;

   logic [CNT_W-1:0]        live_count_ff, live_count_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [RESULT_CNT_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   esa_rsp_type             rsp_item_ff;

   // Handshake
   assign scan_busy = |match_vec;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = scan_busy || !out_free;
   assign accept    = req_valid && !req_stall;

   // Decode slot and stack top onto the rows
   assign slot_idx = IDX_W'(req_item.slot);
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_hit
      assign slot_hit[i]   = (32'(req_item.slot) == i);
      assign create_hit[i] = (stack_entry[0] == IDX_W'(i));
   end

   assign full       = (live_count_ff == CNT_W'(MAX_SLOTS));
   assign slot_alive = |(slot_hit & alive_vec);
   assign refused    = (live_count_ff <= CNT_W'(1)) || !slot_alive;
   assign any_match  = |match_now_vec;

   // Scan: emit on a set match bit, skip clear ones
   assign rest_zero = ((match_vec >> 1) == '0);
   assign cap_hit   = (emit_cnt_ff == RESULT_CNT_W'(MAX_RESULTS - 1));
   assign emit      = scan_busy && match_vec[0] && out_free;

   always_comb begin
      cell_ctl            = '0;
      cell_ctl.mask       = req_item.component_mask;
      cell_ctl.create_go  = accept && (req_item.op == OP_CREATE) && !full;
      cell_ctl.remove_go  = accept && (req_item.op == OP_REMOVE) && !refused;
      cell_ctl.toggle_go  = accept && (req_item.op == OP_TOGGLE);
      cell_ctl.query_load = accept && (req_item.op == OP_QUERY);
      cell_ctl.scan_shift = scan_busy && (!match_vec[0] || out_free);
      cell_ctl.scan_clear = emit && cap_hit;
   end

   assign stack_ctl.push = cell_ctl.remove_go;
   assign stack_ctl.pop  = cell_ctl.create_go;

   // Row of slot cells; match bits shift toward cell zero
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
      if (i == MAX_SLOTS - 1) begin : g_end
         assign match_up[i] = 1'b0;
      end else begin : g_mid
         assign match_up[i] = match_vec[i+1];
      end
      esa_slot_cell u_slot (
         .clock         (clock),
         .reset         (reset),
         .ctl           (cell_ctl),
         .create_sel    (create_hit[i]),
         .slot_sel      (slot_hit[i]),
         .match_from_up (match_up[i]),
         .alive         (alive_vec[i]),
         .match_now     (match_now_vec[i]),
         .match_held    (match_vec[i])
      );
   end

   // Row of stack cells; cell zero is the top of the free list
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_stack
      if (i == 0) begin : g_top
         assign stack_above[i] = slot_idx;
      end else begin : g_mid
         assign stack_above[i] = stack_entry[i-1];
      end
      if (i == MAX_SLOTS - 1) begin : g_bot
         assign stack_below[i] = '0;
      end else begin : g_low
         assign stack_below[i] = stack_entry[i+1];
      end
      esa_stack_cell #(
         .IDX_W       (IDX_W),
         .RESET_VALUE (i)
      ) u_stack (
         .clock      (clock),
         .reset      (reset),
         .ctl        (stack_ctl),
         .from_above (stack_above[i]),
         .from_below (stack_below[i]),
         .entry      (stack_entry[i])
      );
   end

   // Advance live count, scan index and emit count
   always_comb begin
      live_count_in = live_count_ff;
      scan_idx_in   = scan_idx_ff;
      emit_cnt_in   = emit_cnt_ff;
      if (cell_ctl.create_go) begin
         live_count_in = live_count_ff + CNT_W'(1);
      end else if (cell_ctl.remove_go) begin
         live_count_in = live_count_ff - CNT_W'(1);
      end
      if (cell_ctl.query_load) begin
         scan_idx_in = '0;
         emit_cnt_in = '0;
      end else begin
         if (cell_ctl.scan_shift) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         if (emit) begin
            emit_cnt_in = emit_cnt_ff + RESULT_CNT_W'(1);
         end
      end
   end

   // Build the result item
   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = ST_OK;
      rsp_in.last        = 1'b1;
      if (emit) begin
         rsp_in.slot_id     = SLOT_W'(scan_idx_ff);
         rsp_in.match_valid = 1'b1;
         rsp_in.last        = rest_zero || cap_hit;
      end else begin
         unique case (req_item.op)
            OP_CREATE: begin
               if (full) begin
                  rsp_in.status  = ST_FULL;
               end else begin
                  rsp_in.slot_id = SLOT_W'(stack_entry[0]);
               end
            end
            OP_REMOVE: begin
               rsp_in.slot_id = req_item.slot;
               if (refused) begin
                  rsp_in.status = ST_REFUSED;
               end
            end
            OP_TOGGLE: begin
               rsp_in.slot_id = req_item.slot;
            end
            OP_QUERY: begin
               rsp_in.slot_id = '0;
            end
            default: begin
               rsp_in.slot_id = '0;
            end
         endcase
      end
   end

   assign rsp_load = emit || (accept && !((req_item.op == OP_QUERY) && any_match));

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_count_ff <= '0;
         scan_idx_ff   <= '0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         live_count_ff <= live_count_in;
         scan_idx_ff   <= scan_idx_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Live count tracks the alive bits
   a_live_count : assert property (@(posedge clock) disable iff (reset)
      $countones(alive_vec) == live_count_ff)
      else $error("live count differs from number of alive slots");

   // While the table is not full, the top of the free list is never an alive slot
   a_top_free : assert property (@(posedge clock) disable iff (reset)
      !full |-> ((create_hit & alive_vec) == '0))
      else $error("free list top points at an alive slot");

   // A created slot is alive afterwards
   a_create_alive : assert property (@(posedge clock) disable iff (reset)
      cell_ctl.create_go |=> ((alive_vec & $past(create_hit)) != '0))
      else $error("created slot not alive");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the entity slot allocator with component-mask query.
`default_nettype none

module testbench;
   import esa_pkg::*;

   localparam int N_SLOTS = MAX_SLOTS_DEFAULT;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_LEN = 50;
   localparam int DRAIN_EVERY = 100;
   localparam logic [MASK_W-1:0] ALL_COMPONENTS = '1;

   // Traffic phases: who idles and how often
   typedef enum logic [1:0] {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } phase_type;

   // Random stimulus episodes
   typedef enum logic [1:0] {
      EP_FILL,
      EP_DRAIN,
      EP_MIXED
   } episode_type;

   // Slot table: alive bit and mask per slot, free stack, live count
   typedef struct packed {
      logic [N_SLOTS-1:0][31:0]       word;
      logic [N_SLOTS-1:0][SLOT_W-1:0] stack;
      logic [5:0]                     live;
   } slot_table_type;

   typedef struct packed {
      esa_req_type item;
      phase_type   phase;
      logic        drain_first;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   esa_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   esa_rsp_type rsp_item;

   slot_table_type gen_table;
   slot_table_type live_table;
   pending_type    pending_items[$];
   esa_rsp_type    expected_rsp[$];
   esa_rsp_type    step_out[$];
   phase_type      cur_phase = PH_STEADY;

   int fail_count = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int matches_checked = 0;
   int full_checked = 0;
   int refused_checked = 0;

   entity_slot_allocator_mask_query_top #(
      .MAX_SLOTS(N_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic slot_table_type empty_table();
      slot_table_type t;
      t = '0;
      for (int i = 0; i < N_SLOTS; i++) begin
         t.stack[i] = SLOT_W'(N_SLOTS - 1 - i);
      end
      return t;
   endfunction

   // Apply one operation to a table; the results land in step_out
   function automatic void apply_op(inout slot_table_type t, input esa_req_type r);
      esa_rsp_type res;
      logic [SLOT_W-1:0] id;
      logic [31:0] w;
      int top;
      step_out.delete();
      res = '0;
      res.status = ST_OK;
      case (r.op)
         OP_CREATE: begin
            res.last = 1'b1;
            if (int'(t.live) >= N_SLOTS) begin
               res.status = ST_FULL;
            end else begin
               t.live = t.live + 6'd1;
               top = N_SLOTS - int'(t.live);
               id = t.stack[top];
               t.word[id] = {1'b1, r.component_mask};
               res.slot_id = id;
            end
            step_out.push_back(res);
         end
         OP_REMOVE: begin
            res.last = 1'b1;
            res.slot_id = r.slot;
            if (t.live <= 6'd1 || int'(r.slot) >= N_SLOTS || !t.word[r.slot][31]) begin
               res.status = ST_REFUSED;
            end else begin
               t.stack[N_SLOTS - int'(t.live)] = r.slot;
               t.live = t.live - 6'd1;
               t.word[r.slot] = '0;
            end
            step_out.push_back(res);
         end
         OP_TOGGLE: begin
            res.last = 1'b1;
            res.slot_id = r.slot;
            if (int'(r.slot) < N_SLOTS) begin
               t.word[r.slot] = t.word[r.slot] ^ {1'b0, r.component_mask};
            end
            step_out.push_back(res);
         end
         default: begin
            // Scan in ascending order, at most MAX_RESULTS matches
            for (int i = 0; i < N_SLOTS && step_out.size() < MAX_RESULTS; i++) begin
               w = t.word[i];
               if (w[31] && ((w[MASK_W-1:0] & r.component_mask) == r.component_mask)) begin
                  res.slot_id = SLOT_W'(i);
                  res.match_valid = 1'b1;
                  step_out.push_back(res);
               end
            end
            if (step_out.size() == 0) begin
               res.last = 1'b1;
               step_out.push_back(res);
            end else begin
               step_out[step_out.size()-1].last = 1'b1;
            end
         end
      endcase
   endfunction

   // Random alive slot of a table, or -1 when none is alive
   function automatic int pick_live(slot_table_type t);
      int alive[$];
      for (int i = 0; i < N_SLOTS; i++) begin
         if (t.word[i][31]) alive.push_back(i);
      end
      if (alive.size() == 0) return -1;
      return alive[$urandom_range(alive.size() - 1)];
   endfunction

   function automatic logic [MASK_W-1:0] rand_mask();
      case ($urandom_range(3))
         0: return MASK_W'($urandom & $urandom & $urandom);
         1: return MASK_W'(1) << $urandom_range(MASK_W - 1);
         2: return MASK_W'($urandom | $urandom);
         default: return MASK_W'($urandom);
      endcase
   endfunction

   function automatic int sender_idle_pct(phase_type ph);
      case (ph)
         PH_SENDER_IDLE: return 60;
         PH_BOTH_IDLE:   return 27;
         default:        return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(phase_type ph);
      case (ph)
         PH_RECEIVER_STALL: return 60;
         PH_BOTH_IDLE:      return 27;
         default:           return 0;
      endcase
   endfunction

   // Queue an item and track the table it leaves behind
   function automatic void add_item(esa_op_type op, int slot, logic [MASK_W-1:0] mask,
                                    phase_type ph, logic drain);
      pending_type p;
      p.item.op = op;
      p.item.slot = SLOT_W'(slot);
      p.item.component_mask = mask;
      p.phase = ph;
      p.drain_first = drain;
      pending_items.push_back(p);
      apply_op(gen_table, p.item);
   endfunction

   // Driver: present items, predict results at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_op(live_table, req_item);
            foreach (step_out[j]) expected_rsp.push_back(step_out[j]);
            items_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_items[0].drain_first && expected_rsp.size() != 0) begin
               req_valid <= 1'b0;
            end else if ($urandom_range(99) < sender_idle_pct(pending_items[0].phase)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_item <= pending_items[0].item;
               cur_phase <= pending_items[0].phase;
               pending_items.pop_front();
            end
         end
      end
   end

   // Monitor: stall at random, compare each result with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result: slot_id %0d status %0d match_valid %0b last %0b",
                      rsp_item.slot_id, rsp_item.status, rsp_item.match_valid, rsp_item.last);
               fail_count++;
            end else begin
               if (rsp_item.slot_id !== expected_rsp[0].slot_id) begin
                  $error("slot_id: expected %0d, got %0d",
                         expected_rsp[0].slot_id, rsp_item.slot_id);
                  fail_count++;
               end
               if (rsp_item.status !== expected_rsp[0].status) begin
                  $error("status: expected %0d, got %0d",
                         expected_rsp[0].status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.match_valid !== expected_rsp[0].match_valid) begin
                  $error("match_valid: expected %0b, got %0b",
                         expected_rsp[0].match_valid, rsp_item.match_valid);
                  fail_count++;
               end
               if (rsp_item.last !== expected_rsp[0].last) begin
                  $error("last: expected %0b, got %0b",
                         expected_rsp[0].last, rsp_item.last);
                  fail_count++;
               end
               results_checked++;
               if (expected_rsp[0].match_valid) matches_checked++;
               if (expected_rsp[0].status == ST_FULL) full_checked++;
               if (expected_rsp[0].status == ST_REFUSED) refused_checked++;
               expected_rsp.pop_front();
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct(cur_phase));
      end
   end

   // Stimulus, reset and end of run
   initial begin
      episode_type episode;
      int ep_left;
      int pick;
      int slot;
      int roll;
      phase_type ph;
      logic drain;
      logic [MASK_W-1:0] mask;
      esa_op_type op;

      gen_table = empty_table();
      live_table = empty_table();

      // Directed: empty table, refusals, dead slots, stack reuse, extreme masks
      add_item(OP_QUERY,  0,  '0,             PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 0,  '0,             PH_STEADY, 1'b0);
      add_item(OP_TOGGLE, 5,  ALL_COMPONENTS, PH_STEADY, 1'b0);
      add_item(OP_CREATE, 0,  ALL_COMPONENTS, PH_STEADY, 1'b0);
      add_item(OP_CREATE, 31, '0,             PH_STEADY, 1'b0);
      add_item(OP_CREATE, 7,  31'h5555_5555,  PH_STEADY, 1'b0);
      add_item(OP_QUERY,  0,  '0,             PH_STEADY, 1'b0);
      add_item(OP_QUERY,  31, ALL_COMPONENTS, PH_STEADY, 1'b0);
      add_item(OP_QUERY,  0,  31'h4000_0001,  PH_STEADY, 1'b0);
      add_item(OP_TOGGLE, 1,  ALL_COMPONENTS, PH_STEADY, 1'b0);
      add_item(OP_QUERY,  0,  ALL_COMPONENTS, PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 5,  '0,             PH_STEADY, 1'b0);
      add_item(OP_CREATE, 0,  31'h2AAA_AAAA,  PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 31, ALL_COMPONENTS, PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 1,  '0,             PH_STEADY, 1'b0);
      add_item(OP_CREATE, 0,  31'h0000_0001,  PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 0,  '0,             PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 2,  '0,             PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 3,  '0,             PH_STEADY, 1'b0);
      add_item(OP_REMOVE, 1,  '0,             PH_STEADY, 1'b0);
      add_item(OP_TOGGLE, 31, 31'h4000_0000,  PH_STEADY, 1'b0);
      add_item(OP_QUERY,  0,  31'h0000_0001,  PH_STEADY, 1'b0);

      // Random: fill, drain and mixed episodes; the first one is a fill episode
      episode = EP_FILL;
      ep_left = 40;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (ep_left == 0) begin
            case ($urandom_range(2))
               0: episode = EP_FILL;
               1: episode = EP_DRAIN;
               default: episode = EP_MIXED;
            endcase
            ep_left = $urandom_range(8, 40);
         end
         ep_left--;
         ph = phase_type'((k / PHASE_LEN) % 4);
         drain = (k % DRAIN_EVERY == 0);
         roll = $urandom_range(99);
         case (episode)
            EP_FILL:  op = roll < 70 ? OP_CREATE : roll < 80 ? OP_QUERY :
                           roll < 90 ? OP_TOGGLE : OP_REMOVE;
            EP_DRAIN: op = roll < 60 ? OP_REMOVE : roll < 75 ? OP_QUERY :
                           roll < 88 ? OP_TOGGLE : OP_CREATE;
            default:  op = esa_op_type'($urandom_range(3));
         endcase
         pick = pick_live(gen_table);
         slot = (pick >= 0 && $urandom_range(99) < 75) ? pick : $urandom_range(N_SLOTS - 1);
         mask = rand_mask();
         // Queries mostly ask for a subset of a live slot's components
         if (op == OP_QUERY) begin
            case ($urandom_range(9))
               0: mask = '0;
               1: mask = ALL_COMPONENTS;
               2, 3: mask = rand_mask();
               default: begin
                  if (pick >= 0) begin
                     mask = gen_table.word[pick][MASK_W-1:0] & MASK_W'($urandom | $urandom);
                  end else begin
                     mask = MASK_W'($urandom & $urandom & $urandom);
                  end
               end
            endcase
         end
         add_item(op, slot, mask, ph, drain);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for all items, then all results, then let the clock run on quietly before the report
      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2 * N_SLOTS + 8) @(posedge clock);

      $display("ran %0d operations, checked %0d results: %0d query matches, %0d full, %0d refused",
               items_accepted, results_checked, matches_checked, full_checked, refused_checked);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("entity_slot_allocator_mask_query_top: match");
      end else begin
         $display("entity_slot_allocator_mask_query_top: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("entity_slot_allocator_mask_query_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
